/* rtl/tpsf_pkg.sv */
// Shared types, constants and signature tables for the TCP payload signature filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tpsf_pkg;

  // Widths of the frame position counter and the latched ingress port.
  localparam int LengthBits = 16;
  localparam int PortBits   = 8;
  localparam int DataBits   = 8;

  localparam logic [LengthBits-1:0] CntMax = '1;

  // Byte positions inside the frame.
  localparam int PosEthHi   = 12;
  localparam int PosEthLo   = 13;
  localparam int PosIhl     = 14;
  localparam int PosFragHi  = 20;
  localparam int PosFragLo  = 21;
  localparam int PosProto   = 23;
  localparam int PosTcpOff  = 46;
  localparam int IpHdrEnd   = 34;
  // Last byte index of a frame that holds the minimal TCP header.
  localparam int MinTcpLast = 53;

  localparam logic [7:0] EthTypeHi = 8'h08;
  localparam logic [7:0] EthTypeLo = 8'h00;
  localparam logic [3:0] IhlNoOpt  = 4'h5;
  localparam logic [7:0] ProtoTcp  = 8'h06;

  // Header flag bits.
  localparam int FlagBits = 3;
  localparam int FlagEth  = 0;
  localparam int FlagIp   = 1;
  localparam int FlagTcp  = 2;

  // Signature table geometry.
  localparam int SigBytes = 21;
  localparam int OffBits  = 5;
  localparam int SelBits  = 3;
  localparam int SigCount = 4;

  typedef struct packed {
    logic [DataBits-1:0] data_byte;
    logic                first_byte;
    logic                last_byte;
    logic [7:0]          in_port;
  } tpsf_byte_t;

  typedef struct packed {
    logic       drop;
    logic [7:0] out_port;
  } tpsf_verdict_t;

  // Character at offset off of signature sel; zero beyond the table.
  function automatic logic [7:0] sig_char(input logic [1:0] sel,
                                          input logic [OffBits-1:0] off);
    logic [SigBytes*8-1:0] text;
    case (sel)
      2'd0:    text = "get /client/bitcomet/";
      2'd1:    text = {"GET /data?fid=", 56'h0};
      2'd2:    text = {"azver", 8'h01, "$", 112'h0};
      2'd3:    text = {8'h13, "bittorrent protocol", 8'h00};
      default: text = '0;
    endcase
    if (int'(off) >= SigBytes) begin
      return 8'h00;
    end
    return text[8*(SigBytes-1-int'(off)) +: 8];
  endfunction

  function automatic logic [OffBits-1:0] sig_len(input logic [1:0] sel);
    logic [OffBits-1:0] len;
    case (sel)
      2'd0:    len = OffBits'(21);
      2'd1:    len = OffBits'(14);
      2'd2:    len = OffBits'(7);
      2'd3:    len = OffBits'(20);
      default: len = '0;
    endcase
    return len;
  endfunction

  // Select code (1..4) of the signature whose first character is b, 0 if none.
  function automatic logic [SelBits-1:0] sig_first(input logic [7:0] b);
    logic [SelBits-1:0] sel;
    sel = '0;
    for (int k = 0; k < SigCount; k++) begin
      if (sig_char(2'(k), '0) == b) begin
        sel = SelBits'(k + 1);
      end
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

/* rtl/tpsf_if.sv */
// Valid/ready channel interfaces for frame words in and verdict words out.
// Depends on tpsf_pkg for the data width.
`default_nettype none

interface tpsf_in_if import tpsf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DataBits-1:0] data_byte;
  logic                first_byte;
  logic                last_byte;
  logic [7:0]          in_port;

  modport source (output valid, data_byte, first_byte, last_byte, in_port, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, in_port, output ready);
endinterface

interface tpsf_out_if;
  logic       valid;
  logic       ready;
  logic       drop;
  logic [7:0] out_port;

  modport source (output valid, drop, out_port, input ready);
  modport sink   (input valid, drop, out_port, output ready);
endinterface

`default_nettype wire

/* rtl/tpsf_in_reg.sv */
// Input register: captures one frame word per cycle while its word is taken.
// Depends on tpsf_pkg and tpsf_in_if.
`default_nettype none

module tpsf_in_reg import tpsf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpsf_in_if.sink     in_i,
  input  wire logic   take_i,
  output logic        valid_o,
  output tpsf_byte_t  word_o
);

  logic       vld_q, vld_d;
  tpsf_byte_t word_q;
  logic       load;

  assign in_i.ready = !vld_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= '{data_byte: in_i.data_byte, first_byte: in_i.first_byte,
                  last_byte: in_i.last_byte, in_port: in_i.in_port};
    end
  end

  assign valid_o = vld_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* rtl/tpsf_inspect.sv */
// Per-frame inspection state: header checks, signature compare and verdict.
// Depends on tpsf_pkg for constants, tables and word types.
`default_nettype none

module tpsf_inspect import tpsf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire tpsf_byte_t  word_i,
  output logic             result_vld_o,
  output tpsf_verdict_t    result_o
);

  logic [LengthBits-1:0] cnt_q, cnt_d, cnt_c, cnt_inc;
  logic [PortBits-1:0]   port_q, port_d;
  logic [FlagBits-1:0]   flags_q, flags_d, flags_c;
  logic [7:0]            eth_hi_q, eth_hi_d, eth_hi_c;
  logic [LengthBits-1:0] ps_q, ps_d, ps_c;
  logic [SelBits-1:0]    sel_q, sel_d, sel_c;
  logic                  hit_q, hit_d, hit_c;

  logic [LengthBits-1:0] diff;
  logic [OffBits-1:0]    off;
  logic                  off_fits;
  logic [1:0]            sig;
  logic [5:0]            thb;
  logic [7:0]            b;
  logic                  drop;

  assign b = word_i.data_byte;

  always_comb begin
    // A first mark restarts the frame at this word.
    cnt_c    = word_i.first_byte ? '0 : cnt_q;
    flags_c  = word_i.first_byte ? '0 : flags_q;
    eth_hi_c = word_i.first_byte ? '0 : eth_hi_q;
    ps_c     = word_i.first_byte ? '0 : ps_q;
    sel_c    = word_i.first_byte ? '0 : sel_q;
    hit_c    = word_i.first_byte ? 1'b0 : hit_q;

    flags_d  = flags_c;
    eth_hi_d = eth_hi_c;
    ps_d     = ps_c;
    sel_d    = sel_c;
    hit_d    = hit_c;
    thb      = {b[7:4], 2'b00};
    sig      = '0;

    case (cnt_c)
      LengthBits'(PosEthHi): eth_hi_d = b;
      LengthBits'(PosEthLo): begin
        if (eth_hi_c == EthTypeHi && b == EthTypeLo) flags_d[FlagEth] = 1'b1;
      end
      LengthBits'(PosIhl): begin
        if (b[3:0] == IhlNoOpt) flags_d[FlagIp] = 1'b1;
      end
      LengthBits'(PosFragHi): begin
        if (b[5:0] != '0) flags_d[FlagIp] = 1'b0;
      end
      LengthBits'(PosFragLo): begin
        if (b != '0) flags_d[FlagIp] = 1'b0;
      end
      LengthBits'(PosProto): begin
        if (b != ProtoTcp) flags_d[FlagIp] = 1'b0;
      end
      LengthBits'(PosTcpOff): begin
        ps_d = LengthBits'(IpHdrEnd) + LengthBits'(thb);
        if (thb != '0) flags_d[FlagTcp] = 1'b1;
      end
      default: ;
    endcase

    diff     = cnt_c - ps_d;
    off      = diff[OffBits-1:0];
    off_fits = (diff >> OffBits) == '0;

    if (flags_d == '1 && cnt_c >= ps_d && cnt_c != CntMax) begin
      if (diff == '0) begin
        sel_d = sig_first(b);
      end else if (sel_d != '0) begin
        sig = 2'(sel_d - SelBits'(1));
        if (off_fits && off < sig_len(sig)) begin
          if (sig_char(sig, off) != b) begin
            sel_d = '0;
          end else if (off == sig_len(sig) - OffBits'(1)) begin
            hit_d = 1'b1;
            sel_d = '0;
          end
        end else begin
          sel_d = '0;
        end
      end
    end

    cnt_inc = (cnt_c != CntMax) ? cnt_c + LengthBits'(1) : cnt_c;
    cnt_d   = cnt_inc;
    port_d  = (cnt_c == '0) ? PortBits'(word_i.in_port) : port_q;

    drop = !flags_d[FlagEth] || (hit_d && cnt_c >= LengthBits'(MinTcpLast));

    // Clear frame state once the verdict is out.
    if (word_i.last_byte) begin
      cnt_d    = '0;
      flags_d  = '0;
      eth_hi_d = '0;
      ps_d     = '0;
      sel_d    = '0;
      hit_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      port_q   <= '0;
      flags_q  <= '0;
      eth_hi_q <= '0;
      ps_q     <= '0;
      sel_q    <= '0;
      hit_q    <= 1'b0;
    end else if (fire_i) begin
      cnt_q    <= cnt_d;
      port_q   <= port_d;
      flags_q  <= flags_d;
      eth_hi_q <= eth_hi_d;
      ps_q     <= ps_d;
      sel_q    <= sel_d;
      hit_q    <= hit_d;
    end
  end

  assign result_vld_o      = fire_i && word_i.last_byte;
  assign result_o.drop     = drop;
  assign result_o.out_port = drop ? 8'h00 : 8'(port_d ^ PortBits'(1));

endmodule

`default_nettype wire

/* rtl/tpsf_out_reg.sv */
// Result register: holds one verdict word until the output channel takes it.
// Depends on tpsf_pkg and tpsf_out_if.
`default_nettype none

module tpsf_out_reg import tpsf_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire tpsf_verdict_t verdict_i,
  output logic               free_o,
  tpsf_out_if.source         out_o
);

  logic          vld_q, vld_d;
  tpsf_verdict_t verdict_q;

  assign free_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign out_o.valid    = vld_q;
  assign out_o.drop     = verdict_q.drop;
  assign out_o.out_port = verdict_q.out_port;

endmodule

`default_nettype wire

/* rtl/tcp_payload_signature_filter_core.sv */
// TCP payload signature filter, top level.
// Throughput: one frame word per cycle while the result register can take each verdict.
// Verdict path: the last word is held in the input register, its verdict is computed
//   combinationally as it advances and is registered in the result register.
// Reset: rst_ni clears all frame state and both valid flags at once; no clearing pass.
// Depends on tpsf_pkg, tpsf_in_if/tpsf_out_if, tpsf_in_reg, tpsf_inspect, tpsf_out_reg.
`default_nettype none

module tcp_payload_signature_filter_core import tpsf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpsf_in_if.sink     in_i,
  tpsf_out_if.source  out_o
);

  logic          word_vld;
  tpsf_byte_t    word;
  logic          advance;
  logic          out_free;
  logic          result_vld;
  tpsf_verdict_t result;

  // Advance a word from the input register into the inspection state.
  // Words that carry no verdict never wait on the output side; a last word
  // holds only while the result register is still occupied.
  assign advance = word_vld && (!word.last_byte || out_free);

  tpsf_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (advance),
    .valid_o (word_vld),
    .word_o  (word)
  );

  // Header checks, signature compare and the verdict on the last word.
  tpsf_inspect u_inspect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .word_i       (word),
    .result_vld_o (result_vld),
    .result_o     (result)
  );

  // Verdict waits here for the downstream consumer.
  tpsf_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (result_vld),
    .verdict_i (result),
    .free_o    (out_free),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

/* sim/tcp_payload_signature_filter_core_tb.sv */
// Testbench for tcp_payload_signature_filter_core: frames go in one word per handshake,
// and each verdict is checked against a behavioral predictor or a pinned table verdict.
// Depends on tpsf_pkg and the tpsf_in_if / tpsf_out_if channel interfaces.
`default_nettype none

module tcp_payload_signature_filter_core_tb import tpsf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Byte positions and header values the verdict depends on.
  localparam int EthHiPos   = 12;
  localparam int EthLoPos   = 13;
  localparam int IhlPos     = 14;
  localparam int FragHiPos  = 20;
  localparam int FragLoPos  = 21;
  localparam int ProtoPos   = 23;
  localparam int TcpOffPos  = 46;
  localparam int HdrEndPos  = 34;
  localparam int MinTcpLen  = 54;
  localparam int CountLimit = (1 << LengthBits) - 1;

  localparam logic [7:0] Ipv4TypeHi = 8'h08;
  localparam logic [7:0] Ipv4TypeLo = 8'h00;
  localparam logic [3:0] PlainIhl   = 4'h5;
  localparam logic [7:0] TcpProto   = 8'h06;

  // Signature codes: 0 means no signature in the payload.
  localparam int SigNone     = 0;
  localparam int SigBitcomet = 1;
  localparam int SigDataFid  = 2;
  localparam int SigAzver    = 3;
  localparam int SigTorrent  = 4;

  // Random part: stop once both counts are reached.
  localparam int RandWords    = 400;
  localparam int RandVerdicts = 4;

  typedef enum int {StallNone, StallCoin, StallSparse, StallLong} stall_mode_e;

  // One frame of stimulus. len 0 ends the frame right after the signature.
  typedef struct {
    int unsigned len;
    logic [15:0] eth;
    logic [7:0]  ihl;
    logic [7:0]  frag_hi;
    logic [7:0]  frag_lo;
    logic [7:0]  proto;
    logic [7:0]  tcp_off;
    int unsigned sig;
    int unsigned cut;      // signature bytes missing at the end of the frame
    int unsigned flip;     // 1-based signature byte to corrupt, 0 for none
    bit          no_first; // leave out the first-word mark
    bit          abort;    // leave out the last-word mark; next frame restarts
    logic [7:0]  port;
    bit          pinned;   // verdict below is known by inspection
    logic        drop;
    logic [7:0]  out_port;
  } frame_row_t;

  typedef struct {
    bit            pinned;
    tpsf_verdict_t v;
  } verdict_pin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tpsf_in_if  in_if();
  tpsf_out_if out_if();

  tcp_payload_signature_filter_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  string p2p_sig [4] = '{"get /client/bitcomet/", "GET /data?fid=", "azver\001$",
                         "\023bittorrent protocol"};

  // Predictor state, a single copy for the frame in progress.
  logic [LengthBits-1:0] pos_cnt;
  logic [7:0]            port_hold;
  logic                  flag_eth, flag_ip, flag_tcp;
  logic [7:0]            eth_hi_q;
  logic [5:0]            tcp_hdr_len;
  logic [LengthBits-1:0] pay_start;
  int unsigned           sig_cand;
  logic                  sig_found;

  tpsf_verdict_t pending_verdicts [$];
  verdict_pin_t  pinned_verdicts [$];

  int unsigned err_cnt       = 0;
  int unsigned burst_left    = 0;
  int unsigned words_sent    = 0;
  int unsigned frames_judged = 0;

  // Directed frames. Rows with pinned = 1 carry a verdict read straight off the rules;
  // the others are judged by the predictor.
  localparam int DirRows = 24;
  frame_row_t dir_rows [DirRows] = '{
    // single word frame: first and last together
    '{1, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigNone, 0, 0, 0, 0, 8'hA5, 1, 1, 8'h00},
    // ends on the high ethertype byte: too short, drop
    '{13, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigNone, 0, 0, 0, 0, 8'h3C, 1, 1, 8'h00},
    // ethertype complete, nothing else: forward
    '{14, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigNone, 0, 0, 0, 0, 8'h00, 1, 0, 8'h01},
    // not IPv4
    '{0, 16'h86DD, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigBitcomet, 0, 0, 0, 0, 8'h10, 1, 1, 8'h00},
    // bitcomet, data fid and azver signatures on a clean header
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigBitcomet, 0, 0, 0, 0, 8'hFF, 1, 1, 8'h00},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigDataFid, 0, 0, 0, 0, 8'h20, 1, 1, 8'h00},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigAzver, 0, 0, 0, 0, 8'h21, 1, 1, 8'h00},
    // no first mark after a finished frame
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigTorrent, 0, 0, 1, 0, 8'h22, 1, 1, 8'h00},
    // signature cut by the end of the frame
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigBitcomet, 1, 0, 0, 0, 8'h12, 1, 0, 8'h13},
    // more-fragments bit, fragment offset, options, not TCP
    '{0, 16'h0800, 8'h45, 8'h20, 8'h00, 8'h06, 8'h50, SigTorrent, 0, 0, 0, 0, 8'h30, 1, 0, 8'h31},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h01, 8'h06, 8'h50, SigDataFid, 0, 0, 0, 0, 8'h31, 1, 0, 8'h30},
    '{0, 16'h0800, 8'h46, 8'h40, 8'h00, 8'h06, 8'h50, SigAzver, 0, 0, 0, 0, 8'h02, 1, 0, 8'h03},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h11, 8'h50, SigBitcomet, 0, 0, 0, 0, 8'h7E, 1, 0, 8'h7F},
    // data offset zero turns the payload check off
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h00, SigBitcomet, 0, 0, 0, 0, 8'h80, 1, 0, 8'h81},
    // data offset 1 and 3: payload starts inside the fixed header
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h10, SigAzver, 0, 0, 0, 0, 8'h0F, 0, 0, 8'h00},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h30, SigTorrent, 0, 0, 0, 0, 8'hF0, 0, 0, 8'h00},
    // largest data offset, and data offset 4
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'hF0, SigDataFid, 0, 0, 0, 0, 8'h55, 1, 1, 8'h00},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h40, SigAzver, 0, 0, 0, 0, 8'hAA, 1, 1, 8'h00},
    // empty payload
    '{54, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigNone, 0, 0, 0, 0, 8'h44, 1, 0, 8'h45},
    // first signature byte corrupted
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigBitcomet, 0, 1, 0, 0, 8'h66, 1, 0, 8'h67},
    // abandoned frame, then a new first mark restarts
    '{40, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigBitcomet, 0, 0, 0, 1, 8'h01, 0, 0, 8'h00},
    '{0, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigDataFid, 0, 0, 0, 0, 8'h03, 1, 1, 8'h00},
    // IP version nibble is ignored
    '{0, 16'h0800, 8'hF5, 8'h40, 8'h00, 8'h06, 8'h50, SigTorrent, 0, 0, 0, 0, 8'h04, 1, 1, 8'h00},
    // plain frame, payload too short for any signature
    '{60, 16'h0800, 8'h45, 8'h40, 8'h00, 8'h06, 8'h50, SigNone, 0, 0, 0, 0, 8'h5A, 1, 0, 8'h5B}
  };

  function automatic int unsigned sig_bytes(input int unsigned sig);
    return (sig == SigNone) ? 0 : p2p_sig[sig-1].len();
  endfunction

  function automatic void clear_frame_state();
    pos_cnt     = '0;
    flag_eth    = 1'b0;
    flag_ip     = 1'b0;
    flag_tcp    = 1'b0;
    eth_hi_q    = '0;
    tcp_hdr_len = '0;
    pay_start   = '0;
    sig_cand    = SigNone;
    sig_found   = 1'b0;
  endfunction

  // Advance the frame state by one accepted word; on the last word queue its verdict.
  task automatic judge_word(input tpsf_byte_t w);
    int unsigned   pos, off, s, frame_len;
    tpsf_verdict_t v;
    if (w.first_byte) clear_frame_state();
    pos = pos_cnt;
    if (pos == 0) port_hold = w.in_port;

    case (pos)
      EthHiPos:  eth_hi_q = w.data_byte;
      EthLoPos:  if (eth_hi_q == Ipv4TypeHi && w.data_byte == Ipv4TypeLo) flag_eth = 1'b1;
      IhlPos:    if (w.data_byte[3:0] == PlainIhl) flag_ip = 1'b1;
      FragHiPos: if (w.data_byte[5:0] != '0) flag_ip = 1'b0;
      FragLoPos: if (w.data_byte != '0) flag_ip = 1'b0;
      ProtoPos:  if (w.data_byte != TcpProto) flag_ip = 1'b0;
      TcpOffPos: begin
        tcp_hdr_len = {w.data_byte[7:4], 2'b00};
        pay_start   = LengthBits'(HdrEndPos + tcp_hdr_len);
        if (tcp_hdr_len != '0) flag_tcp = 1'b1;
      end
      default: ;
    endcase

    // Track the signature candidate from the first payload byte on.
    if (flag_eth && flag_ip && flag_tcp && pos >= pay_start && pos < CountLimit) begin
      off = pos - pay_start;
      if (off == 0) begin
        sig_cand = SigNone;
        for (int k = 0; k < 4; k++) begin
          if (p2p_sig[k][0] == w.data_byte) sig_cand = k + 1;
        end
      end else if (sig_cand != SigNone) begin
        s = sig_cand - 1;
        if (off < p2p_sig[s].len()) begin
          if (p2p_sig[s][off] != w.data_byte) begin
            sig_cand = SigNone;
          end else if (off == p2p_sig[s].len() - 1) begin
            sig_found = 1'b1;
            sig_cand  = SigNone;
          end
        end else begin
          sig_cand = SigNone;
        end
      end
    end

    if (pos_cnt != '1) pos_cnt++;

    if (w.last_byte) begin
      frame_len  = pos + 1;
      v.drop     = !flag_eth || (sig_found && frame_len >= MinTcpLen);
      v.out_port = v.drop ? 8'h00 : port_hold ^ 8'h01;
      pending_verdicts.push_back(v);
      clear_frame_state();
    end
  endtask

  // Drive one word, opening a new burst after a random gap when the old one runs out.
  task automatic send_word(input tpsf_byte_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= w.data_byte;
    in_if.first_byte <= w.first_byte;
    in_if.last_byte  <= w.last_byte;
    in_if.in_port    <= w.in_port;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // Build the frame bytes: random fill, signature at the payload start, header on top.
  task automatic send_frame(input frame_row_t r);
    logic [7:0]   body [$];
    int unsigned  ps, slen, n;
    tpsf_byte_t   w;
    verdict_pin_t pin;
    ps   = HdrEndPos + 4 * r.tcp_off[7:4];
    slen = sig_bytes(r.sig);
    n    = (r.len != 0) ? r.len : ps + slen - r.cut;
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) body.push_back(8'($urandom));
    for (int k = 0; k < slen; k++) begin
      if (ps + k < n) body[ps+k] = p2p_sig[r.sig-1][k];
    end
    if (r.flip != 0 && ps + r.flip - 1 < n) body[ps+r.flip-1] ^= 8'($urandom_range(1, 255));
    if (n > EthHiPos)  body[EthHiPos]  = r.eth[15:8];
    if (n > EthLoPos)  body[EthLoPos]  = r.eth[7:0];
    if (n > IhlPos)    body[IhlPos]    = r.ihl;
    if (n > FragHiPos) body[FragHiPos] = r.frag_hi;
    if (n > FragLoPos) body[FragLoPos] = r.frag_lo;
    if (n > ProtoPos)  body[ProtoPos]  = r.proto;
    if (n > TcpOffPos) body[TcpOffPos] = r.tcp_off;

    for (int k = 0; k < n; k++) begin
      w.data_byte  = body[k];
      w.first_byte = (k == 0) && !r.no_first;
      w.last_byte  = (k == n - 1) && !r.abort;
      // only the port on position 0 counts; scramble the rest
      w.in_port    = (k == 0) ? r.port : 8'($urandom);
      if (w.last_byte) begin
        pin.pinned     = r.pinned;
        pin.v.drop     = r.drop;
        pin.v.out_port = r.out_port;
        pinned_verdicts.push_back(pin);
      end
      send_word(w);
    end
    if (!r.abort) frames_judged++;
  endtask

  // Hold the sender until every verdict in flight has come out.
  task automatic drain_verdicts();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Input side: predict on every accepted word. A pinned verdict replaces the predicted one.
  always @(posedge clk_i) begin : word_monitor
    tpsf_byte_t   w;
    verdict_pin_t pin;
    if (rst_ni && in_if.valid && in_if.ready) begin
      w.data_byte  = in_if.data_byte;
      w.first_byte = in_if.first_byte;
      w.last_byte  = in_if.last_byte;
      w.in_port    = in_if.in_port;
      judge_word(w);
      if (w.last_byte) begin
        pin = pinned_verdicts.pop_front();
        if (pin.pinned) pending_verdicts[$] = pin.v;
      end
    end
  end

  // Output side: compare each accepted verdict with the oldest one waiting.
  always @(posedge clk_i) begin : verdict_monitor
    tpsf_verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected verdict drop=%0b out_port=%02h",
                 $time, out_if.drop, out_if.out_port);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.drop !== want.drop) begin
          err_cnt++;
          $display("%0t: drop mismatch, expected %0b, got %0b", $time, want.drop, out_if.drop);
        end
        if (out_if.out_port !== want.out_port) begin
          err_cnt++;
          $display("%0t: out_port mismatch, expected %02h, got %02h",
                   $time, want.out_port, out_if.out_port);
        end
      end
    end
  end

  // Receiver: switch between stall patterns at random, long stalls included.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned phase_left, hold_low;
    out_if.ready = 1'b0;
    mode         = StallNone;
    phase_left   = 0;
    hold_low     = 0;
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        mode       = stall_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (mode)
        StallNone:   out_if.ready <= 1'b1;
        StallCoin:   out_if.ready <= 1'($urandom_range(0, 1));
        StallSparse: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_low == 0) begin
            hold_low = $urandom_range(5, 30);
            out_if.ready <= 1'b1;
          end else begin
            hold_low--;
            out_if.ready <= 1'b0;
          end
        end
      endcase
    end
  end

  initial begin : stimulus
    frame_row_t  r;
    int unsigned kind, ps, slen;
    bit          need_first;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    in_if.in_port    = '0;
    clear_frame_state();
    port_hold = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_frame(dir_rows[i]);

    // Let the pipe run dry once before the random part.
    drain_verdicts();
    words_sent    = 0;
    frames_judged = 0;
    need_first    = 1'b0;

    // Mostly well-formed IPv4/TCP frames, most with a signature, some mutated;
    // the rest random noise and abandoned frames.
    while (words_sent < RandWords || frames_judged < RandVerdicts) begin
      kind       = $urandom_range(0, 9);
      r.port     = 8'($urandom);
      r.no_first = !need_first && ($urandom_range(0, 7) == 0);
      r.abort    = (kind == 9);
      r.pinned   = 1'b0;
      r.drop     = 1'b0;
      r.out_port = '0;
      r.cut      = 0;
      r.flip     = 0;
      r.sig      = $urandom_range(SigNone, SigTorrent);
      if (kind <= 6) begin
        r.eth     = {Ipv4TypeHi, Ipv4TypeLo};
        r.ihl     = {4'($urandom), PlainIhl};
        r.frag_hi = {2'($urandom), 6'h00};
        r.frag_lo = 8'h00;
        r.proto   = TcpProto;
        r.tcp_off = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                 : {4'($urandom_range(4, 15)), 4'($urandom)};
        case ($urandom_range(0, 11))
          0:       r.eth     = 16'($urandom);
          1:       r.ihl     = 8'($urandom);
          2:       r.frag_hi = 8'($urandom);
          3:       r.frag_lo = 8'($urandom);
          4:       r.proto   = 8'($urandom);
          default: ;
        endcase
        ps   = HdrEndPos + 4 * r.tcp_off[7:4];
        slen = sig_bytes(r.sig);
        if (slen != 0 && $urandom_range(0, 3) == 0) r.cut = $urandom_range(1, slen);
        if (slen != 0 && $urandom_range(0, 4) == 0) r.flip = $urandom_range(1, slen);
        r.len = ps + slen - r.cut + $urandom_range(0, 6);
      end else begin
        r.eth     = ($urandom_range(0, 1) == 0) ? {Ipv4TypeHi, Ipv4TypeLo} : 16'($urandom);
        r.ihl     = 8'($urandom);
        r.frag_hi = 8'($urandom);
        r.frag_lo = 8'($urandom);
        r.proto   = 8'($urandom);
        r.tcp_off = 8'($urandom);
        r.len     = r.abort ? $urandom_range(1, 60) : $urandom_range(1, 100);
      end
      send_frame(r);
      need_first = r.abort;
      if ($urandom_range(0, 24) == 0) drain_verdicts();
    end

    drain_verdicts();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tcp_payload_signature_filter_core_tb OK");
    end else begin
      $display("tcp_payload_signature_filter_core_tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run; the slowest legal run is well under this.
  initial begin : watchdog
    #20ms;
    $display("tcp_payload_signature_filter_core_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
